FILE: design/dmxrdm_pkg.sv
package dmxrdm_pkg;

   // default geometry
   localparam int DMX_SLOTS_DEF        = 512;
   localparam int RDM_FRAME_BYTES_DEF  = 256;
   localparam int RDM_RING_ENTRIES_DEF = 8;
   localparam int UID_BYTES            = 6;

   // field widths
   localparam int POS_W   = 10;
   localparam int ENTRY_W = 3;
   localparam int TIME_W  = 32;

   // event codes on req_op
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_BREAK = 2'd1;
   localparam logic [1:0] OP_TIMER = 2'd2;

   // packet start codes
   localparam logic [1:0] START_NONE = 2'd0;
   localparam logic [1:0] START_DMX  = 2'd1;
   localparam logic [1:0] START_RDM  = 2'd2;

   // line bytes
   localparam logic [7:0] SC_DMX        = 8'h00;
   localparam logic [7:0] SC_RDM        = 8'hCC;
   localparam logic [7:0] SUB_START_RDM = 8'h01;
   localparam logic [7:0] DISC_PREAMBLE = 8'hFE;
   localparam logic [7:0] DISC_SEPARATE = 8'hAA;

   localparam logic [3:0] DISC_EUID_BYTES = 4'(2 * UID_BYTES);
   localparam logic [3:0] DISC_ECS_BYTES  = 4'd4;

   typedef struct packed {
      logic              write_valid;
      logic              write_to_rdm;
      logic [POS_W-1:0]  write_index;
      logic [7:0]        write_byte;
      logic [ENTRY_W-1:0] rdm_entry;
      logic              dmx_frame_done;
      logic [POS_W-1:0]  frame_slots;
      logic              rdm_frame_done;
      logic [1:0]        packet_start;
      logic [TIME_W-1:0] interval_us;
      logic [3:0]        receive_state;
   } result_type;

endpackage

FILE: design/dmx_rdm_receive_framer_core.sv
// path: a word accepted on req_ is held in the input register; the framer step then writes
//   its result into the result register, which drives rsp_ (the step waits while it is full)
// throughput: one word per cycle while rsp_ready holds; the framer state is one register set updated per step
// reset: synchronous, active high; clears framer state, ring head, timestamps and the
//   discovery capture enable
module dmx_rdm_receive_framer_core #(
   parameter int DMX_SLOTS        = dmxrdm_pkg::DMX_SLOTS_DEF,
   parameter int RDM_FRAME_BYTES  = dmxrdm_pkg::RDM_FRAME_BYTES_DEF,
   parameter int RDM_RING_ENTRIES = dmxrdm_pkg::RDM_RING_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // event input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_op,
   input  logic [7:0]                     req_data,
   input  logic [dmxrdm_pkg::TIME_W-1:0]  req_timestamp_us,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_write_valid,
   output logic                           rsp_write_to_rdm,
   output logic [dmxrdm_pkg::POS_W-1:0]   rsp_write_index,
   output logic [7:0]                     rsp_write_byte,
   output logic [dmxrdm_pkg::ENTRY_W-1:0] rsp_rdm_entry,
   output logic                           rsp_dmx_frame_done,
   output logic [dmxrdm_pkg::POS_W-1:0]   rsp_frame_slots,
   output logic                           rsp_rdm_frame_done,
   output logic [1:0]                     rsp_packet_start,
   output logic [dmxrdm_pkg::TIME_W-1:0]  rsp_interval_us,
   output logic [3:0]                     rsp_receive_state,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_discovery_capture_enable
);

   // config register
   logic                           capture_en_ff;

   // input register stage
   logic                           in_valid_ff;
   logic [1:0]                     op_ff;
   logic [7:0]                     data_ff;
   logic [dmxrdm_pkg::TIME_W-1:0]  ts_ff;

   // result register stage
   logic                           out_valid_ff;
   dmxrdm_pkg::result_type         out_ff;

   logic                           out_free;
   logic                           step;
   dmxrdm_pkg::result_type         step_result;

   // the framer steps when the input stage holds a word and the result
   // register is empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   // config writes are taken at any time; the user must issue them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_en_ff <= 1'b0;
      end else if (csr_valid) begin
         capture_en_ff <= csr_discovery_capture_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         data_ff <= req_data;
         ts_ff   <= req_timestamp_us;
      end
   end

   // per-word framing: state machine, checksum, ring head, slot timing
   dmxrdm_framer #(
      .DMX_SLOTS        (DMX_SLOTS),
      .RDM_FRAME_BYTES  (RDM_FRAME_BYTES),
      .RDM_RING_ENTRIES (RDM_RING_ENTRIES)
   ) u_framer (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .capture_en   (capture_en_ff),
      .op           (op_ff),
      .data         (data_ff),
      .timestamp_us (ts_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= step_result;
      end
   end

   // result word fan-out
   assign rsp_valid           = out_valid_ff;
   assign rsp_write_valid     = out_ff.write_valid;
   assign rsp_write_to_rdm    = out_ff.write_to_rdm;
   assign rsp_write_index     = out_ff.write_index;
   assign rsp_write_byte      = out_ff.write_byte;
   assign rsp_rdm_entry       = out_ff.rdm_entry;
   assign rsp_dmx_frame_done  = out_ff.dmx_frame_done;
   assign rsp_frame_slots     = out_ff.frame_slots;
   assign rsp_rdm_frame_done  = out_ff.rdm_frame_done;
   assign rsp_packet_start    = out_ff.packet_start;
   assign rsp_interval_us     = out_ff.interval_us;
   assign rsp_receive_state   = out_ff.receive_state;

endmodule

FILE: design/dmxrdm_framer.sv
module dmxrdm_framer #(
   parameter int DMX_SLOTS        = dmxrdm_pkg::DMX_SLOTS_DEF,
   parameter int RDM_FRAME_BYTES  = dmxrdm_pkg::RDM_FRAME_BYTES_DEF,
   parameter int RDM_RING_ENTRIES = dmxrdm_pkg::RDM_RING_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic                          capture_en,
   input  logic [1:0]                    op,
   input  logic [7:0]                    data,
   input  logic [dmxrdm_pkg::TIME_W-1:0] timestamp_us,
   output dmxrdm_pkg::result_type        result
);

   localparam int HEAD_W = (RDM_RING_ENTRIES > 2) ? $clog2(RDM_RING_ENTRIES) : 1;
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RDM_RING_ENTRIES - 1);
   localparam logic [dmxrdm_pkg::POS_W-1:0] DMX_LAST  = dmxrdm_pkg::POS_W'(DMX_SLOTS);
   localparam logic [dmxrdm_pkg::POS_W-1:0] RDM_LIMIT = dmxrdm_pkg::POS_W'(RDM_FRAME_BYTES);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_BREAK = 4'd1,
      PH_DMX   = 4'd2,
      PH_RDM   = 4'd3,
      PH_CSH   = 4'd4,
      PH_CSL   = 4'd5,
      PH_DPRE  = 4'd6,
      PH_DEUID = 4'd7,
      PH_DECS  = 4'd8
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [dmxrdm_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]                    csum_ff, csum_in;
   logic [7:0]                     len_ff, len_in;
   logic [7:0]                     sub_ff, sub_in;
   logic [3:0]                     dcnt_ff, dcnt_in;
   logic [HEAD_W-1:0]              head_ff, head_in;
   logic [dmxrdm_pkg::TIME_W-1:0]  brk_time_ff, brk_time_in;
   logic [dmxrdm_pkg::TIME_W-1:0]  evt_time_ff, evt_time_in;
   logic [dmxrdm_pkg::TIME_W-1:0]  slot_iv_ff, slot_iv_in;

   logic [HEAD_W+2:0]              head_ext;
   logic                           put_ok;
   logic [dmxrdm_pkg::TIME_W-1:0]  evt_gap;
   logic [3:0]                     dcnt_next;
   logic [15:0]                    csum_next;
   dmxrdm_pkg::result_type         res;

   assign head_ext = {3'b000, head_ff};
   assign put_ok   = (pos_ff < RDM_LIMIT);
   assign evt_gap  = timestamp_us - evt_time_ff;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      csum_in     = csum_ff;
      len_in      = len_ff;
      sub_in      = sub_ff;
      dcnt_in     = dcnt_ff;
      head_in     = head_ff;
      brk_time_in = brk_time_ff;
      evt_time_in = evt_time_ff;
      slot_iv_in  = slot_iv_ff;
      dcnt_next   = dcnt_ff + 4'd1;
      csum_next   = csum_ff;
      res         = '0;
      res.rdm_entry = head_ext[2:0];

      unique case (op)
         dmxrdm_pkg::OP_BREAK: begin
            phase_in       = PH_BREAK;
            res.interval_us = timestamp_us - brk_time_ff;
            brk_time_in    = timestamp_us;
            evt_time_in    = timestamp_us;
         end
         dmxrdm_pkg::OP_TIMER: begin
            // slot timeout ends the dmx frame
            if (phase_ff == PH_DMX && evt_gap > slot_iv_ff) begin
               phase_in            = PH_IDLE;
               res.dmx_frame_done  = 1'b1;
               res.frame_slots     = pos_ff - 10'd1;
            end
         end
         dmxrdm_pkg::OP_BYTE: begin
            evt_time_in = timestamp_us;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (capture_en && data == dmxrdm_pkg::DISC_PREAMBLE) begin
                     phase_in         = PH_DPRE;
                     res.write_valid  = 1'b1;
                     res.write_to_rdm = 1'b1;
                     res.write_byte   = dmxrdm_pkg::DISC_PREAMBLE;
                     pos_in           = 10'd1;
                  end
               end
               PH_BREAK: begin
                  if (data == dmxrdm_pkg::SC_DMX) begin
                     phase_in         = PH_DMX;
                     res.write_valid  = 1'b1;
                     pos_in           = 10'd1;
                     res.packet_start = dmxrdm_pkg::START_DMX;
                  end else if (data == dmxrdm_pkg::SC_RDM) begin
                     phase_in         = PH_RDM;
                     csum_in          = {8'h00, dmxrdm_pkg::SC_RDM};
                     len_in           = 8'h00;
                     sub_in           = 8'h00;
                     res.packet_start = dmxrdm_pkg::START_RDM;
                     res.write_valid  = 1'b1;
                     res.write_to_rdm = 1'b1;
                     res.write_byte   = dmxrdm_pkg::SC_RDM;
                     pos_in           = 10'd1;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_DMX: begin
                  res.write_valid = 1'b1;
                  res.write_index = pos_ff;
                  res.write_byte  = data;
                  pos_in          = pos_ff + 10'd1;
                  slot_iv_in      = evt_gap;
                  res.interval_us = evt_gap;
                  if (pos_ff >= DMX_LAST) begin
                     phase_in            = PH_IDLE;
                     res.dmx_frame_done  = 1'b1;
                     res.frame_slots     = DMX_LAST;
                  end
               end
               PH_DPRE: begin
                  if (data == dmxrdm_pkg::DISC_PREAMBLE || data == dmxrdm_pkg::DISC_SEPARATE)
                  begin
                     if (put_ok) begin
                        res.write_valid  = 1'b1;
                        res.write_to_rdm = 1'b1;
                        res.write_index  = pos_ff;
                        res.write_byte   = data;
                        pos_in           = pos_ff + 10'd1;
                        if (data == dmxrdm_pkg::DISC_SEPARATE) begin
                           phase_in = PH_DEUID;
                           dcnt_in  = 4'd0;
                        end
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_RDM, PH_CSH, PH_CSL, PH_DEUID, PH_DECS: begin
                  if (!put_ok) begin
                     // store bound reached, drop the frame
                     phase_in = PH_IDLE;
                  end else begin
                     res.write_valid  = 1'b1;
                     res.write_to_rdm = 1'b1;
                     res.write_index  = pos_ff;
                     res.write_byte   = data;
                     pos_in           = pos_ff + 10'd1;
                     unique case (phase_ff)
                        PH_RDM: begin
                           csum_in = csum_ff + {8'h00, data};
                           if (pos_ff == 10'd1) begin
                              sub_in = data;
                           end
                           if (pos_ff == 10'd2) begin
                              len_in = data;
                           end
                           if (pos_in >= 10'd3 && pos_in == {2'b00, len_in}) begin
                              phase_in = PH_CSH;
                           end
                        end
                        PH_CSH: begin
                           csum_in  = csum_ff - {data, 8'h00};
                           phase_in = PH_CSL;
                        end
                        PH_CSL: begin
                           csum_next = csum_ff - {8'h00, data};
                           csum_in   = csum_next;
                           phase_in  = PH_IDLE;
                           if (csum_next == 16'h0000 && sub_ff == dmxrdm_pkg::SUB_START_RDM)
                           begin
                              head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + HEAD_W'(1);
                              res.rdm_frame_done = 1'b1;
                           end
                        end
                        PH_DEUID: begin
                           dcnt_in = dcnt_next;
                           if (dcnt_next == dmxrdm_pkg::DISC_EUID_BYTES) begin
                              phase_in = PH_DECS;
                              dcnt_in  = 4'd0;
                           end
                        end
                        default: begin
                           dcnt_in = dcnt_next;
                           if (dcnt_next == dmxrdm_pkg::DISC_ECS_BYTES) begin
                              head_in  = (head_ff == HEAD_LAST) ? '0 : head_ff + HEAD_W'(1);
                              res.rdm_frame_done = 1'b1;
                              phase_in = PH_IDLE;
                           end
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      res.receive_state = phase_in;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         pos_ff      <= '0;
         csum_ff     <= '0;
         len_ff      <= '0;
         sub_ff      <= '0;
         dcnt_ff     <= '0;
         head_ff     <= '0;
         brk_time_ff <= '0;
         evt_time_ff <= '0;
         slot_iv_ff  <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         csum_ff     <= csum_in;
         len_ff      <= len_in;
         sub_ff      <= sub_in;
         dcnt_ff     <= dcnt_in;
         head_ff     <= head_in;
         brk_time_ff <= brk_time_in;
         evt_time_ff <= evt_time_in;
         slot_iv_ff  <= slot_iv_in;
      end
   end

endmodule
